[rtl/core/tae_pkg.sv]
package tae_pkg;

  // Width of each edge component field on the input word.
  localparam int FIELD_W = 16;
  // Width of the area field on the result word.
  localparam int AREA_W  = 32;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [AREA_W-1:0]  area_t;

endpackage

[rtl/core/tae_if.sv]
// Input channel: one word holds both edge vectors.
interface tae_in_if;
  import tae_pkg::*;

  logic   valid;
  logic   ready;
  field_t t_x;
  field_t t_y;
  field_t t_z;
  field_t r_x;
  field_t r_y;
  field_t r_z;

  modport source (output valid, output t_x, output t_y, output t_z,
                  output r_x, output r_y, output r_z, input ready);
  modport sink   (input valid, input t_x, input t_y, input t_z,
                  input r_x, input r_y, input r_z, output ready);
endinterface

// Result channel: one word per triangle.
interface tae_out_if;
  import tae_pkg::*;

  logic  valid;
  logic  ready;
  area_t area;

  modport source (output valid, output area, input ready);
  modport sink   (input valid, input area, output ready);
endinterface

[rtl/core/tae_isqrt_pipe.sv]
// Floor square root, one result bit resolved per register stage.
module tae_isqrt_pipe #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_radicand,
  output logic            out_valid,
  output logic [RW-1:0]   out_root
);

  localparam int NW = 2 * RW;

  logic [NW-1:0] rem_r [0:RW-2];
  logic [RW-1:0] q_r   [0:RW-1];
  logic          v_r   [0:RW-1];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int B = RW - 1 - s;

    logic [NW-1:0] rem_in;
    logic [RW-1:0] q_in;
    logic          v_in;
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_nxt;
    logic [RW-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign rem_in = in_radicand;
      assign q_in   = '0;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign v_in   = v_r[s-1];
    end

    // Growth of the square when bit B of the root is set: 2*q*2^B + 2^(2B).
    assign trial = (NW'(q_in) << (B + 1)) | (NW'(1) << (2 * B));

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        q_nxt   = q_in | (RW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s] <= q_nxt;
      end
    end

    if (s < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
        end
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = q_r[RW-1];

endmodule

[rtl/core/triangle_area_from_edges_top.sv]
// Channel  Role    Word contents
// -------  ------  ---------------------------------------------------------
// in_ch    sink    t_x t_y t_z r_x r_y r_z, signed Q7.8 edge components
// out_ch   source  area, unsigned, 17 fraction bits (floor of the root)
//
// One word is taken every cycle while the skid register is empty. The depth
// is set by the square root, which resolves one root bit per stage; four
// stages in front form the products, differences with magnitudes, squares
// and their sum.
// Reset (rst_n low, synchronous) empties every stage and the output.
// A stall on out_ch freezes the whole pipeline as soon as a result lands
// in the skid register, so in_ch.ready is a registered condition.
module triangle_area_from_edges_top #(
  parameter int COMPONENT_WIDTH = 16
) (
  input logic     clk,
  input logic     rst_n,
  tae_in_if.sink  in_ch,
  tae_out_if.source out_ch
);
  import tae_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int PW = 2 * W;   // products, cross-component magnitudes, root
  localparam int SW = 4 * W;   // squares and their sum

  // The pipeline moves as a whole whenever the skid register is empty.
  logic en;

  // Components are read from their low W bits and sign-extended.
  logic signed [W-1:0] tx, ty, tz, rx, ry, rz;

  assign tx = in_ch.t_x[W-1:0];
  assign ty = in_ch.t_y[W-1:0];
  assign tz = in_ch.t_z[W-1:0];
  assign rx = in_ch.r_x[W-1:0];
  assign ry = in_ch.r_y[W-1:0];
  assign rz = in_ch.r_z[W-1:0];

  // Stage 1: the six products of the cross product.
  logic signed [PW-1:0] p_tyrz_r, p_rytz_r, p_tzrx_r, p_rztx_r, p_txry_r, p_rxty_r;
  logic                 v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_tyrz_r <= ty * rz;
      p_rytz_r <= ry * tz;
      p_tzrx_r <= tz * rx;
      p_rztx_r <= rz * tx;
      p_txry_r <= tx * ry;
      p_rxty_r <= rx * ty;
    end
  end

  // Stage 2: cross components and their magnitudes. A difference is at most
  // 2^(2W-1) in size, so its magnitude fits PW bits unsigned.
  logic signed [PW:0] cx, cy, cz;
  logic        [PW:0] ax, ay, az;
  logic [PW-1:0]      mx_r, my_r, mz_r;
  logic               v2_r;

  assign cx = {p_tyrz_r[PW-1], p_tyrz_r} - {p_rytz_r[PW-1], p_rytz_r};
  assign cy = {p_tzrx_r[PW-1], p_tzrx_r} - {p_rztx_r[PW-1], p_rztx_r};
  assign cz = {p_txry_r[PW-1], p_txry_r} - {p_rxty_r[PW-1], p_rxty_r};

  assign ax = cx[PW] ? (~cx + 1'b1) : cx;
  assign ay = cy[PW] ? (~cy + 1'b1) : cy;
  assign az = cz[PW] ? (~cz + 1'b1) : cz;

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= ax[PW-1:0];
      my_r <= ay[PW-1:0];
      mz_r <= az[PW-1:0];
    end
  end

  // Stage 3: squares of the magnitudes.
  logic [SW-1:0] sqx_r, sqy_r, sqz_r;
  logic          v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= mx_r * mx_r;
      sqy_r <= my_r * my_r;
      sqz_r <= mz_r * mz_r;
    end
  end

  // Stage 4: the sum stays below 3 * 2^(4W-2), so it cannot carry out.
  logic [SW-1:0] sum_r;
  logic          v4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sqx_r + sqy_r + sqz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Square root stages. The root is the length in units of 2^-16, which
  // read in units of 2^-17 is the area, so the halving costs nothing.
  logic          tail_valid;
  logic [PW-1:0] tail_root;

  tae_isqrt_pipe #(
    .RW (PW)
  ) u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v4_r),
    .in_radicand (sum_r),
    .out_valid   (tail_valid),
    .out_root    (tail_root)
  );

  // Output register with a skid register behind it. While the output word
  // waits, one more result can still leave the pipeline into the skid.
  logic  out_valid_r, out_valid_nxt;
  area_t out_area_r, out_area_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  area_t skid_area_r, skid_area_nxt;
  logic  out_free;
  area_t tail_area;

  assign en        = !skid_valid_r;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign tail_area = AREA_W'(tail_root);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_area_nxt   = out_area_r;
    skid_valid_nxt = skid_valid_r;
    skid_area_nxt  = skid_area_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_area_nxt   = skid_area_r;
        skid_valid_nxt = 1'b0;
      end else if (en && tail_valid) begin
        out_valid_nxt = 1'b1;
        out_area_nxt  = tail_area;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (en && tail_valid) begin
      skid_valid_nxt = 1'b1;
      skid_area_nxt  = tail_area;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_area_r  <= out_area_nxt;
    skid_area_r <= skid_area_nxt;
  end

  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.area  = out_area_r;

endmodule
